// File: hdl/ect_pkg.sv
// shared types, constants and character class helpers of the expression tokenizer
package ect_pkg;

    // parameter defaults
    localparam int DEF_MAX_POSITION = 255;
    localparam int DEF_INT_BITS     = 32;
    localparam int DEF_FRAC_BITS    = 16;
    localparam int DEF_FRAC_DIGITS  = 6;

    // depth of the token queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // fixed widths of the result fields
    localparam int VALUE_W = 48;
    localparam int CODE_W  = 8;
    localparam int OUTPOS_W = 8;
    localparam int TDATA_W = 72;

    // character codes
    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

    // token kinds as they leave the block
    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_IDENT  = 2'd1,
        KIND_SYMBOL = 2'd2,
        KIND_STOP   = 2'd3
    } kind_t;

    // scanner mode between characters
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_DIVIDE = 2'd1,
        BK_CLOSE  = 2'd2,
        BK_OWN    = 2'd3
    } back_state_t;

    // what one character produced: a token it closes and a token it forms itself
    typedef struct packed {
        logic       close_valid;
        kind_t      close_kind;
        logic       int_sat;
        logic       own_valid;
        kind_t      own_kind;
        logic [7:0] own_code;
    } ect_ctrl_t;

    // powers of ten for fraction scaling
    localparam logic [31:0] POW_TEN [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    function automatic logic [31:0] pow_ten(input logic [3:0] idx);
        logic [31:0] val;
        val = (idx <= 4'd9) ? POW_TEN[idx] : 32'd1;
        return val;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        logic res;
        res = ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
              ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
              (c == CHAR_UNDERSCORE);
        return res;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        logic res;
        res = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        return res;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        logic res;
        res = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
        return res;
    endfunction

endpackage

// File: hdl/ect_front.sv
// character scanner: classifies bytes, tracks position and accumulates number digits
module ect_front #(
    parameter int MAX_POSITION = ect_pkg::DEF_MAX_POSITION,
    parameter int INT_BITS     = ect_pkg::DEF_INT_BITS,
    parameter int FRAC_DIGITS  = ect_pkg::DEF_FRAC_DIGITS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     accept,
    input  logic [7:0]                               char_in,
    output logic                                     push,
    output ect_pkg::ect_ctrl_t                       push_ctrl,
    output logic [$clog2(MAX_POSITION+1)-1:0]        push_pos,
    output logic [INT_BITS-1:0]                      push_int,
    output logic [$clog2(10**FRAC_DIGITS)-1:0]       push_frac,
    output logic [$clog2(FRAC_DIGITS+1)-1:0]         push_cnt
);
    import ect_pkg::*;

    localparam int POS_W  = $clog2(MAX_POSITION + 1);
    localparam int FACC_W = $clog2(10**FRAC_DIGITS);
    localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int IP_W   = INT_BITS + 4;
    localparam int FP_W   = FACC_W + 4;

    mode_t               mode_reg, mode_next;
    logic [POS_W-1:0]    pos_reg, pos_next, pos_adv;
    logic [INT_BITS-1:0] int_reg, int_next;
    logic                sat_reg, sat_next;
    logic [FACC_W-1:0]   frac_reg, frac_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                seen_reg, seen_next;
    logic                closed_reg, closed_next;

    logic is_let, is_dig, is_dot, is_num, cont_ident, cont_num;
    logic [3:0] digit;

    // absorb path operands and results
    logic [INT_BITS-1:0] base_int, abs_int;
    logic                base_sat, abs_sat;
    logic [FACC_W-1:0]   base_frac, abs_frac;
    logic [CNT_W-1:0]    base_cnt, abs_cnt;
    logic                base_seen, abs_seen;
    logic                base_closed, abs_closed;
    logic [IP_W-1:0]     iprod;
    logic [FP_W-1:0]     fprod;

    // character classes
    assign is_let     = is_letter(char_in);
    assign is_dig     = is_digit(char_in);
    assign is_dot     = (char_in == CHAR_DOT);
    assign is_num     = is_dig || is_dot;
    assign digit      = char_in[3:0];
    assign cont_ident = (mode_reg == MODE_IDENT) && (is_let || is_dig);
    assign cont_num   = (mode_reg == MODE_NUMBER) && is_num;
    assign pos_adv    = (pos_reg < POS_W'(MAX_POSITION)) ? pos_reg + 1'b1 : pos_reg;

    // digit absorb: continues the running number or starts from a cleared one
    always_comb begin
        base_int    = cont_num ? int_reg    : '0;
        base_sat    = cont_num ? sat_reg    : 1'b0;
        base_frac   = cont_num ? frac_reg   : '0;
        base_cnt    = cont_num ? cnt_reg    : '0;
        base_seen   = cont_num ? seen_reg   : 1'b0;
        base_closed = cont_num ? closed_reg : 1'b0;
        iprod = (IP_W'(base_int) << 3) + (IP_W'(base_int) << 1) + IP_W'(digit);
        fprod = (FP_W'(base_frac) << 3) + (FP_W'(base_frac) << 1) + FP_W'(digit);
        abs_int    = base_int;
        abs_sat    = base_sat;
        abs_frac   = base_frac;
        abs_cnt    = base_cnt;
        abs_seen   = base_seen;
        abs_closed = base_closed;
        if (!base_closed) begin
            if (is_dot) begin
                if (base_seen) begin
                    abs_closed = 1'b1;
                end else begin
                    abs_seen = 1'b1;
                end
            end else if (!base_seen) begin
                if (!base_sat) begin
                    if (iprod[IP_W-1:INT_BITS] != '0) begin
                        abs_int = '1;
                        abs_sat = 1'b1;
                    end else begin
                        abs_int = iprod[INT_BITS-1:0];
                    end
                end
            end else if (base_cnt < CNT_W'(FRAC_DIGITS)) begin
                abs_frac = fprod[FACC_W-1:0];
                abs_cnt  = base_cnt + 1'b1;
            end
        end
    end

    // scanner decision per accepted character
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        int_next    = int_reg;
        sat_next    = sat_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        seen_next   = seen_reg;
        closed_next = closed_reg;
        push_ctrl   = '0;
        push_ctrl.close_kind = KIND_NUMBER;
        push_ctrl.own_kind   = KIND_SYMBOL;
        if (accept) begin
            if (cont_ident) begin
                pos_next = pos_adv;
            end else if (cont_num) begin
                int_next    = abs_int;
                sat_next    = abs_sat;
                frac_next   = abs_frac;
                cnt_next    = abs_cnt;
                seen_next   = abs_seen;
                closed_next = abs_closed;
                pos_next    = pos_adv;
            end else begin
                // close any open token, then look at the byte itself
                push_ctrl.close_valid = (mode_reg != MODE_IDLE);
                push_ctrl.close_kind  = (mode_reg == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
                push_ctrl.int_sat     = sat_reg;
                mode_next   = MODE_IDLE;
                int_next    = '0;
                sat_next    = 1'b0;
                frac_next   = '0;
                cnt_next    = '0;
                seen_next   = 1'b0;
                closed_next = 1'b0;
                if (char_in == CHAR_NUL) begin
                    push_ctrl.own_valid = 1'b1;
                    push_ctrl.own_kind  = KIND_STOP;
                    pos_next = '0;
                end else if (is_blank(char_in)) begin
                    pos_next = pos_adv;
                end else if (is_let) begin
                    mode_next = MODE_IDENT;
                    pos_next  = pos_adv;
                end else if (is_num) begin
                    mode_next   = MODE_NUMBER;
                    int_next    = abs_int;
                    sat_next    = abs_sat;
                    frac_next   = abs_frac;
                    cnt_next    = abs_cnt;
                    seen_next   = abs_seen;
                    closed_next = abs_closed;
                    pos_next    = pos_adv;
                end else begin
                    push_ctrl.own_valid = 1'b1;
                    push_ctrl.own_kind  = KIND_SYMBOL;
                    push_ctrl.own_code  = char_in;
                    pos_next = pos_adv;
                end
            end
        end
    end

    // token payload comes from the state before this character
    assign push      = push_ctrl.close_valid || push_ctrl.own_valid;
    assign push_pos  = pos_reg;
    assign push_int  = int_reg;
    assign push_frac = frac_reg;
    assign push_cnt  = cnt_reg;

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            int_reg    <= '0;
            sat_reg    <= 1'b0;
            frac_reg   <= '0;
            cnt_reg    <= '0;
            seen_reg   <= 1'b0;
            closed_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            int_reg    <= int_next;
            sat_reg    <= sat_next;
            frac_reg   <= frac_next;
            cnt_reg    <= cnt_next;
            seen_reg   <= seen_next;
            closed_reg <= closed_next;
        end
    end

    // position stays within its saturation limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_POSITION))
        else $error("front: position beyond limit");

    // a saturated integer part holds all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> (int_reg == '1))
        else $error("front: saturated integer not all ones");

endmodule

// File: hdl/ect_queue.sv
// small token queue between scanner and result sequencer
module ect_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ect_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // the scanner never offers a token while the queue is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue: push while full");

endmodule

// File: hdl/ect_back.sv
// result sequencer: scales fractions by long division and emits up to two tokens
module ect_back #(
    parameter int MAX_POSITION = ect_pkg::DEF_MAX_POSITION,
    parameter int INT_BITS     = ect_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS    = ect_pkg::DEF_FRAC_BITS,
    parameter int FRAC_DIGITS  = ect_pkg::DEF_FRAC_DIGITS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     q_valid,
    output logic                                     q_pop,
    input  ect_pkg::ect_ctrl_t                       q_ctrl,
    input  logic [$clog2(MAX_POSITION+1)-1:0]        q_pos,
    input  logic [INT_BITS-1:0]                      q_int,
    input  logic [$clog2(10**FRAC_DIGITS)-1:0]       q_frac,
    input  logic [$clog2(FRAC_DIGITS+1)-1:0]         q_cnt,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [ect_pkg::TDATA_W-1:0]              m_tdata,
    output logic [1:0]                               m_tuser,
    output logic                                     m_tlast
);
    import ect_pkg::*;

    localparam int POS_W  = $clog2(MAX_POSITION + 1);
    localparam int FACC_W = $clog2(10**FRAC_DIGITS);
    localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int DIV_W  = $clog2(10**FRAC_DIGITS + 1);
    localparam int STEP_W = $clog2(FRAC_BITS + 1);
    localparam int WORD_W = INT_BITS + FRAC_BITS;

    back_state_t         state_reg, state_next;
    ect_ctrl_t           ctrl_reg, ctrl_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [INT_BITS-1:0] int_reg, int_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [FRAC_BITS-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [TDATA_W-1:0]  tdata_reg, tdata_next;
    logic [1:0]          tuser_reg, tuser_next;
    logic                tlast_reg, tlast_next;

    logic                needs_div;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      div_ext;
    logic [DIV_W:0]      trial_diff;
    logic [WORD_W+VALUE_W-1:0] word_wide;
    logic [VALUE_W-1:0]  close_value;
    logic [POS_W+OUTPOS_W-1:0] pos_wide;
    logic [OUTPOS_W-1:0] pos_out;
    logic [TDATA_W-1:0]  close_data, own_data;

    // fraction scaling is needed only for an unsaturated number with fraction digits
    assign needs_div = q_ctrl.close_valid && (q_ctrl.close_kind == KIND_NUMBER) &&
                       !q_ctrl.int_sat && (q_cnt != '0);

    // one restoring long-division step
    assign trial      = {rem_reg, 1'b0};
    assign div_ext    = {1'b0, div_reg};
    assign trial_diff = trial - div_ext;

    // token words built from the working registers
    assign word_wide   = {{VALUE_W{1'b0}}, int_reg, quot_reg};
    assign close_value = ctrl_reg.int_sat ? {VALUE_W{1'b1}} : word_wide[VALUE_W-1:0];
    assign pos_wide    = {{OUTPOS_W{1'b0}}, pos_reg};
    assign pos_out     = pos_wide[OUTPOS_W-1:0];

    always_comb begin
        close_data = '0;
        close_data[CODE_W +: OUTPOS_W] = pos_out;
        if (ctrl_reg.close_kind == KIND_NUMBER) begin
            close_data[CODE_W + OUTPOS_W +: VALUE_W] = close_value;
            close_data[CODE_W + OUTPOS_W + VALUE_W]  = ctrl_reg.int_sat;
        end
        own_data = '0;
        own_data[0 +: CODE_W]        = ctrl_reg.own_code;
        own_data[CODE_W +: OUTPOS_W] = pos_out;
    end

    // sequencer: pop, divide, present closed token, present own token
    always_comb begin
        state_next = state_reg;
        ctrl_next  = ctrl_reg;
        pos_next   = pos_reg;
        int_next   = int_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        tdata_next = tdata_reg;
        tuser_next = tuser_reg;
        tlast_next = tlast_reg;
        q_pop      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ctrl_next  = q_ctrl;
                    pos_next   = q_pos;
                    int_next   = q_int;
                    rem_next   = DIV_W'(q_frac);
                    div_next   = DIV_W'(pow_ten(4'(q_cnt)));
                    quot_next  = '0;
                    step_next  = needs_div ? STEP_W'(FRAC_BITS) : '0;
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE: begin
                if (step_reg != '0) begin
                    if (trial >= div_ext) begin
                        rem_next  = trial_diff[DIV_W-1:0];
                        quot_next = {quot_reg[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        rem_next  = trial[DIV_W-1:0];
                        quot_next = {quot_reg[FRAC_BITS-2:0], 1'b0};
                    end
                    step_next = step_reg - 1'b1;
                end else if (ctrl_reg.close_valid) begin
                    tdata_next = close_data;
                    tuser_next = ctrl_reg.close_kind;
                    tlast_next = !ctrl_reg.own_valid;
                    state_next = BK_CLOSE;
                end else begin
                    tdata_next = own_data;
                    tuser_next = ctrl_reg.own_kind;
                    tlast_next = 1'b1;
                    state_next = BK_OWN;
                end
            end
            BK_CLOSE: begin
                if (m_tready) begin
                    if (ctrl_reg.own_valid) begin
                        tdata_next = own_data;
                        tuser_next = ctrl_reg.own_kind;
                        tlast_next = 1'b1;
                        state_next = BK_OWN;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_OWN: begin
                if (m_tready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working and output registers
    always_ff @(posedge aclk) begin
        ctrl_reg  <= ctrl_next;
        pos_reg   <= pos_next;
        int_reg   <= int_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
        tlast_reg <= tlast_next;
    end

    assign m_tvalid = (state_reg == BK_CLOSE) || (state_reg == BK_OWN);
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

    // division runs its full count before any token is shown
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIVIDE && step_reg != '0) |=> (state_reg == BK_DIVIDE))
        else $error("back: division cut short");

    // a closed token without a following token is the last one of its character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLOSE && m_tready && !ctrl_reg.own_valid) |=>
        (state_reg == BK_IDLE))
        else $error("back: stray token after closed token");

    // the token shown in the own state always ends its character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_OWN) |-> m_tlast)
        else $error("back: own token not marked last");

endmodule

// File: hdl/expression_char_tokenizer_unit.sv
// top level of the expression character tokenizer
//
//  channel | direction | payload
//  s_      | in        | tdata[7:0] character
//  m_      | out       | tdata: symbol_code, position, number_value, value_overflow;
//          |           | tuser: token_kind; tlast: last token of its character
//
// The scanner takes one character per cycle while the token queue has room.
// A character that yields tokens is popped by the result side, which then runs
// a long division (one quotient bit a cycle) for a number with fraction digits
// and shows each token in turn; it pops the next entry only once it is idle again.
// Synchronous active-low reset returns the line to index 0 and empties the queue.
// The queue decouples the sides: a stalled m_tready fills it, then s_tready drops.
module expression_char_tokenizer_unit #(
    parameter int MAX_POSITION = ect_pkg::DEF_MAX_POSITION,
    parameter int INT_BITS     = ect_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS    = ect_pkg::DEF_FRAC_BITS,
    parameter int FRAC_DIGITS  = ect_pkg::DEF_FRAC_DIGITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] character
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] symbol_code, [15:8] position, [63:16] number_value,
    // [64] value_overflow, [71:65] zero
    output logic [ect_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,   // [1:0] token_kind
    output logic                        m_tlast
);
    import ect_pkg::*;

    localparam int POS_W  = $clog2(MAX_POSITION + 1);
    localparam int FACC_W = $clog2(10**FRAC_DIGITS);
    localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam int CTRL_W = $bits(ect_ctrl_t);
    localparam int ENTRY_W = CTRL_W + POS_W + INT_BITS + FACC_W + CNT_W;

    logic                accept;
    logic                push, q_full, q_pop, q_valid;
    ect_ctrl_t           push_ctrl, q_ctrl;
    logic [POS_W-1:0]    push_pos, q_pos;
    logic [INT_BITS-1:0] push_int, q_int;
    logic [FACC_W-1:0]   push_frac, q_frac;
    logic [CNT_W-1:0]    push_cnt, q_cnt;
    logic [ENTRY_W-1:0]  push_entry, pop_entry;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // scanner
    ect_front #(
        .MAX_POSITION (MAX_POSITION),
        .INT_BITS     (INT_BITS),
        .FRAC_DIGITS  (FRAC_DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .char_in   (s_tdata),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_pos  (push_pos),
        .push_int  (push_int),
        .push_frac (push_frac),
        .push_cnt  (push_cnt)
    );

    // token queue
    assign push_entry = {push_ctrl, push_pos, push_int, push_frac, push_cnt};
    assign {q_ctrl, q_pos, q_int, q_frac, q_cnt} = pop_entry;

    ect_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .not_empty (q_valid)
    );

    // result sequencer
    ect_back #(
        .MAX_POSITION (MAX_POSITION),
        .INT_BITS     (INT_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .FRAC_DIGITS  (FRAC_DIGITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_ctrl   (q_ctrl),
        .q_pos    (q_pos),
        .q_int    (q_int),
        .q_frac   (q_frac),
        .q_cnt    (q_cnt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the expression character tokenizer with a scoreboard class
module tb_top;
    import ect_pkg::*;

    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int ITEM_TARGET  = 1400;
    localparam int LONG_LINE    = 280;

    // receiver stall patterns
    typedef enum logic [1:0] {
        READY_ALWAYS = 2'd0,
        READY_HALF   = 2'd1,
        READY_SPARSE = 2'd2,
        READY_THIRD  = 2'd3
    } ready_mode_t;

    // scanner copy and the queue of tokens it predicts
    class token_scoreboard;
        typedef struct packed {
            ect_pkg::kind_t kind;
            logic [7:0]     code;
            logic [7:0]     pos;
            logic [47:0]    value;
            logic           ovf;
            logic           last;
        } token_t;

        token_t predicted_tokens[$];
        int errors;
        int chars_taken;
        int tokens_checked;
        int kind_count[4];
        int overflow_count;
        int line_len;
        int longest_line;

        ect_pkg::mode_t  mode;
        int unsigned     char_pos;
        longint unsigned int_acc;
        bit              int_sat;
        longint unsigned frac_acc;
        int unsigned     frac_cnt;
        bit              point_seen;
        bit              value_closed;

        function new();
            errors = 0;
            chars_taken = 0;
            tokens_checked = 0;
            overflow_count = 0;
            line_len = 0;
            longest_line = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
            clear_line();
        endfunction

        static function bit char_is_alpha(logic [7:0] c);
            return (c >= ect_pkg::CHAR_LOWER_A && c <= ect_pkg::CHAR_LOWER_Z) ||
                   (c >= ect_pkg::CHAR_UPPER_A && c <= ect_pkg::CHAR_UPPER_Z) ||
                   (c == ect_pkg::CHAR_UNDERSCORE);
        endfunction

        static function bit char_is_dec(logic [7:0] c);
            return (c >= ect_pkg::CHAR_ZERO) && (c <= ect_pkg::CHAR_NINE);
        endfunction

        static function bit char_is_space(logic [7:0] c);
            return (c == ect_pkg::CHAR_SPACE) || (c == ect_pkg::CHAR_TAB) ||
                   (c == ect_pkg::CHAR_CR) || (c == ect_pkg::CHAR_LF);
        endfunction

        function void clear_number();
            int_acc = 0;
            int_sat = 1'b0;
            frac_acc = 0;
            frac_cnt = 0;
            point_seen = 1'b0;
            value_closed = 1'b0;
        endfunction

        function void clear_line();
            mode = ect_pkg::MODE_IDLE;
            char_pos = 0;
            clear_number();
        endfunction

        function int pending();
            return predicted_tokens.size();
        endfunction

        // position counter saturates on long lines
        function void step_pos();
            if (char_pos < ect_pkg::DEF_MAX_POSITION)
                char_pos++;
        endfunction

        function longint unsigned ten_to(int unsigned n);
            longint unsigned p;
            p = 1;
            repeat (n) p = p * 10;
            return p;
        endfunction

        // accumulate integer and fraction digits; a second point freezes the value
        function void take_num_char(logic [7:0] c);
            longint unsigned int_limit;
            int_limit = (64'd1 << ect_pkg::DEF_INT_BITS) - 64'd1;
            if (value_closed)
                return;
            if (c == ect_pkg::CHAR_DOT) begin
                if (point_seen)
                    value_closed = 1'b1;
                else
                    point_seen = 1'b1;
                return;
            end
            if (!point_seen) begin
                if (!int_sat) begin
                    int_acc = int_acc * 10 + longint'(c - ect_pkg::CHAR_ZERO);
                    if (int_acc > int_limit) begin
                        int_acc = int_limit;
                        int_sat = 1'b1;
                    end
                end
            end else if (frac_cnt < ect_pkg::DEF_FRAC_DIGITS) begin
                frac_acc = frac_acc * 10 + longint'(c - ect_pkg::CHAR_ZERO);
                frac_cnt++;
            end
        endfunction

        // fixed-point word of the open number, truncated
        function logic [47:0] number_word();
            longint unsigned frac;
            longint unsigned word;
            if (int_sat)
                return '1;
            frac = 0;
            if (frac_cnt > 0)
                frac = (frac_acc << ect_pkg::DEF_FRAC_BITS) / ten_to(frac_cnt);
            word = (int_acc << ect_pkg::DEF_FRAC_BITS) | frac;
            return word[47:0];
        endfunction

        // predict the tokens of one accepted character
        function void note_char(logic [7:0] c);
            token_t made[2];
            int n;
            n = 0;
            chars_taken++;
            line_len++;
            if (mode == ect_pkg::MODE_IDENT && (char_is_alpha(c) || char_is_dec(c))) begin
                step_pos();
                return;
            end
            if (mode == ect_pkg::MODE_NUMBER && (char_is_dec(c) || c == ect_pkg::CHAR_DOT)) begin
                take_num_char(c);
                step_pos();
                return;
            end
            // the character ends any open token
            if (mode == ect_pkg::MODE_IDENT) begin
                made[n] = '{ect_pkg::KIND_IDENT, 8'h00, char_pos[7:0], 48'h0, 1'b0, 1'b0};
                n++;
            end else if (mode == ect_pkg::MODE_NUMBER) begin
                made[n] = '{ect_pkg::KIND_NUMBER, 8'h00, char_pos[7:0], number_word(),
                            int_sat, 1'b0};
                n++;
            end
            mode = ect_pkg::MODE_IDLE;
            clear_number();
            // then what the character forms itself
            if (c == ect_pkg::CHAR_NUL) begin
                made[n] = '{ect_pkg::KIND_STOP, 8'h00, char_pos[7:0], 48'h0, 1'b0, 1'b0};
                n++;
                if (line_len > longest_line)
                    longest_line = line_len;
                line_len = 0;
                clear_line();
            end else if (char_is_space(c)) begin
                step_pos();
            end else if (char_is_alpha(c)) begin
                mode = ect_pkg::MODE_IDENT;
                step_pos();
            end else if (char_is_dec(c) || c == ect_pkg::CHAR_DOT) begin
                mode = ect_pkg::MODE_NUMBER;
                take_num_char(c);
                step_pos();
            end else begin
                made[n] = '{ect_pkg::KIND_SYMBOL, c, char_pos[7:0], 48'h0, 1'b0, 1'b0};
                n++;
                step_pos();
            end
            for (int i = 0; i < n; i++) begin
                made[i].last = (i == n - 1);
                predicted_tokens.push_back(made[i]);
            end
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result transaction with the oldest prediction
        function void check_token(logic [TDATA_W-1:0] data, logic [1:0] user, logic last);
            token_t want;
            if (predicted_tokens.size() == 0) begin
                $error("unexpected token: kind %0d position %0d", user, data[15:8]);
                errors++;
                return;
            end
            want = predicted_tokens.pop_front();
            tokens_checked++;
            kind_count[int'(want.kind)]++;
            if (want.ovf)
                overflow_count++;
            compare_field("token_kind", want.kind, user);
            compare_field("symbol_code", want.code, data[7:0]);
            compare_field("position", want.pos, data[15:8]);
            compare_field("number_value", want.value, data[63:16]);
            compare_field("value_overflow", want.ovf, data[64]);
            compare_field("last_of_item", want.last, last);
            compare_field("tdata padding", 0, data[TDATA_W-1:65]);
        endfunction

        function void report_leftovers();
            if (predicted_tokens.size() != 0) begin
                $error("%0d predicted tokens never arrived", predicted_tokens.size());
                errors += predicted_tokens.size();
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    token_scoreboard sb = new();
    bit              hold_request = 1'b0;
    int              burst_left = 0;
    logic [7:0]      line_buf[$];

    expression_char_tokenizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // present one character and wait for its transaction
    task automatic send_char(input logic [7:0] c);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_char(c);
    endtask

    // sender bursts with random gaps, some long stretches without gaps
    task automatic offer_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        send_char(c);
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_char(s[i]);
    endtask

    function automatic logic [7:0] pick_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CHAR_LOWER_A + 8'(r);
        if (r < 52)
            return CHAR_UPPER_A + 8'(r - 26);
        return CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic void add_ident();
        line_buf.push_back(pick_alpha());
        repeat ($urandom_range(0, 7))
            line_buf.push_back(($urandom_range(0, 3) == 0) ? pick_digit() : pick_alpha());
    endfunction

    // numbers of several shapes: plain, fraction, near saturation, dotted, points only
    function automatic void add_number();
        int shape;
        string near_limit;
        near_limit = "42949672";
        shape = $urandom_range(0, 9);
        if (shape <= 2) begin
            repeat ($urandom_range(1, 5)) line_buf.push_back(pick_digit());
        end else if (shape <= 4) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(pick_digit());
            line_buf.push_back(CHAR_DOT);
            repeat ($urandom_range(1, 9)) line_buf.push_back(pick_digit());
        end else if (shape == 5) begin
            if ($urandom_range(0, 1)) begin
                foreach (near_limit[i]) line_buf.push_back(near_limit[i]);
                repeat ($urandom_range(2, 3)) line_buf.push_back(pick_digit());
            end else begin
                repeat ($urandom_range(9, 12)) line_buf.push_back(pick_digit());
            end
            if ($urandom_range(0, 1)) begin
                line_buf.push_back(CHAR_DOT);
                repeat ($urandom_range(1, 4)) line_buf.push_back(pick_digit());
            end
        end else if (shape == 6) begin
            line_buf.push_back(CHAR_DOT);
            repeat ($urandom_range(1, 7)) line_buf.push_back(pick_digit());
        end else if (shape == 7) begin
            line_buf.push_back(pick_digit());
            repeat ($urandom_range(3, 10))
                line_buf.push_back(($urandom_range(0, 2) == 0) ? CHAR_DOT : pick_digit());
        end else if (shape == 8) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(CHAR_DOT);
        end else begin
            repeat ($urandom_range(1, 4)) line_buf.push_back(pick_digit());
            line_buf.push_back(CHAR_DOT);
        end
    endfunction

    function automatic void add_symbol();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (token_scoreboard::char_is_alpha(c) || token_scoreboard::char_is_dec(c) ||
               token_scoreboard::char_is_space(c) || c == CHAR_DOT);
        line_buf.push_back(c);
    endfunction

    function automatic void add_blank();
        int r;
        repeat ($urandom_range(1, 2)) begin
            r = $urandom_range(0, 3);
            line_buf.push_back((r == 0) ? CHAR_SPACE : (r == 1) ? CHAR_TAB :
                               (r == 2) ? CHAR_CR : CHAR_LF);
        end
    endfunction

    function automatic void add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            add_ident();
        else if (r < 65)
            add_number();
        else if (r < 85)
            add_symbol();
        else if (r < 93)
            add_blank();
        else
            line_buf.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 1))
            add_blank();
    endfunction

    // one line of tokens ended by a zero byte; some lines are raw noise
    function automatic void build_line(input int min_len);
        int n;
        line_buf.delete();
        if (min_len == 0 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 12);
            while (n > 0 || line_buf.size() < min_len) begin
                add_token();
                n--;
            end
        end
        line_buf.push_back(CHAR_NUL);
    endfunction

    // result side: stall patterns and one long hold-off
    initial begin : result_sink
        int hold_left;
        int phase_left;
        int cycle_count;
        ready_mode_t ready_mode;
        hold_left = 0;
        phase_left = 0;
        cycle_count = 0;
        ready_mode = READY_ALWAYS;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (aresetn && m_tvalid && m_tready)
                sb.check_token(m_tdata, m_tuser, m_tlast);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    ready_mode = ready_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(16, 128);
                end
                phase_left--;
                case (ready_mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:      m_tready <= (cycle_count % 3 == 0);
                endcase
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int line_count;
        line_count = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identifier edges, saturated integer, lone point, high bytes
        send_text("_Z9+4294967296 .");
        offer_char(8'h80);
        offer_char(CHAR_NUL);
        // directed: long fraction, second point, points only, stop after symbol
        send_text("0.1234567.8\t..");
        offer_char(8'hFF);
        offer_char(CHAR_NUL);

        // random lines, a few of them long enough to saturate the position
        while (sb.chars_taken < ITEM_TARGET) begin
            build_line((line_count % 25 == 5) ? LONG_LINE : 0);
            foreach (line_buf[i])
                offer_char(line_buf[i]);
            line_count++;
            if (line_count == 8)
                hold_request = 1'b1;
            if (line_count == 20) begin
                // let every predicted token drain before going on
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
                @(posedge aclk);
                burst_left = 0;
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.report_leftovers();

        $display("covered %0d characters (%0d random lines, longest %0d), %0d tokens checked",
                 sb.chars_taken, line_count, sb.longest_line, sb.tokens_checked);
        $display("numbers %0d, identifiers %0d, symbols %0d, stops %0d, saturated %0d, errors %0d",
                 sb.kind_count[KIND_NUMBER], sb.kind_count[KIND_IDENT],
                 sb.kind_count[KIND_SYMBOL], sb.kind_count[KIND_STOP],
                 sb.overflow_count, sb.errors);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

endmodule
